@@ hw/rtl/rrs_pkg.sv @@
// Shared types, codes and constants of the round-robin station issue block.
`timescale 1ns / 1ps

package rrs_pkg;

    localparam int NUM_STATIONS_DEF = 4;
    localparam int ROB_ENTRIES_DEF  = 16;
    localparam int DATA_W           = 32;
    localparam int TAG_W            = 4;
    localparam int TAG_CODES        = 1 << TAG_W;
    localparam int PORT_IDX_W       = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CYCLE = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_SLT = 2'd2,
        OP_BAD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  en;
        logic [PORT_IDX_W-1:0] station;
        t_op                   op;
        logic [DATA_W-1:0]     a;
        logic [DATA_W-1:0]     b;
        logic [TAG_W-1:0]      tag;
        logic                  busy;
        logic                  ready;
        logic                  fresh;
        logic                  waiting;
    } t_st_write;

    typedef struct packed {
        logic clr_fresh;
        logic clr_wait;
    } t_st_update;

    typedef struct packed {
        logic busy;
        logic ready;
        logic fresh;
        logic waiting;
    } t_st_flags;

endpackage

@@ hw/rtl/rrs_alu.sv @@
// Shared integer unit: add, subtract and signed set-less-than on one adder.
`timescale 1ns / 1ps

module rrs_alu (
    input  rrs_pkg::t_op                  i_op,
    input  logic [rrs_pkg::DATA_W-1:0]    i_a,
    input  logic [rrs_pkg::DATA_W-1:0]    i_b,
    output logic [rrs_pkg::DATA_W-1:0]    o_res,
    output logic                          o_bad
);

    localparam int DW = rrs_pkg::DATA_W;

    logic          w_sub;
    logic [DW-1:0] w_addend;
    logic [DW:0]   w_sum;

    // Operands are sign-extended by one bit so that the top bit of the
    // difference is the signed less-than flag.
    assign w_sub    = (i_op != rrs_pkg::OP_ADD);
    assign w_addend = w_sub ? ~i_b : i_b;
    assign w_sum    = {i_a[DW-1], i_a} + {w_addend[DW-1], w_addend} + {{DW{1'b0}}, w_sub};

    always_comb begin
        o_res = '0;
        o_bad = 1'b0;
        case (i_op)
            rrs_pkg::OP_ADD: begin
                o_res = w_sum[DW-1:0];
            end
            rrs_pkg::OP_SUB: begin
                o_res = w_sum[DW-1:0];
            end
            rrs_pkg::OP_SLT: begin
                o_res = {{(DW-1){1'b0}}, w_sum[DW]};
            end
            default: begin
                o_bad = 1'b1;
            end
        endcase
    end

endmodule

@@ hw/rtl/rrs_table.sv @@
// Reservation station table: entry storage, status flags and their updates.
`timescale 1ns / 1ps

module rrs_table #(
    parameter int NUM_STATIONS = rrs_pkg::NUM_STATIONS_DEF,
    parameter int ROB_ENTRIES  = rrs_pkg::ROB_ENTRIES_DEF,
    parameter int SW           = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrs_pkg::t_st_write            i_wr,
    input  logic [SW-1:0]                 i_idx,
    input  rrs_pkg::t_st_update           i_upd,
    output rrs_pkg::t_st_flags            o_flags,
    output rrs_pkg::t_op                  o_op,
    output logic [rrs_pkg::DATA_W-1:0]    o_a,
    output logic [rrs_pkg::DATA_W-1:0]    o_b,
    output logic [rrs_pkg::TAG_W-1:0]     o_tag
);

    logic [NUM_STATIONS-1:0]       r_busy;
    logic [NUM_STATIONS-1:0]       r_ready;
    logic [NUM_STATIONS-1:0]       r_fresh;
    logic [NUM_STATIONS-1:0]       r_wait;
    rrs_pkg::t_op                  r_op  [NUM_STATIONS];
    logic [rrs_pkg::DATA_W-1:0]    r_a   [NUM_STATIONS];
    logic [rrs_pkg::DATA_W-1:0]    r_b   [NUM_STATIONS];
    logic [rrs_pkg::TAG_W-1:0]     r_tag [NUM_STATIONS];

    logic [NUM_STATIONS-1:0]       w_hit;
    logic [rrs_pkg::TAG_W-1:0]     w_tag_tab [rrs_pkg::TAG_CODES];
    logic [rrs_pkg::TAG_W-1:0]     w_tag_mod;

    // Tags are folded into the reorder buffer range through a constant table.
    for (genvar g = 0; g < rrs_pkg::TAG_CODES; g++) begin : g_tag_tab
        localparam int TagVal = g % ROB_ENTRIES;
        assign w_tag_tab[g] = rrs_pkg::TAG_W'(TagVal);
    end

    assign w_tag_mod = w_tag_tab[i_wr.tag];

    always_comb begin
        for (int k = 0; k < NUM_STATIONS; k++) begin
            w_hit[k] = i_wr.en && (int'(i_wr.station) == k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_ready <= '0;
            r_fresh <= '0;
            r_wait  <= '0;
        end else begin
            for (int k = 0; k < NUM_STATIONS; k++) begin
                if (w_hit[k]) begin
                    r_busy[k]  <= i_wr.busy;
                    r_ready[k] <= i_wr.ready;
                    r_fresh[k] <= i_wr.fresh;
                    r_wait[k]  <= i_wr.waiting;
                end else if (i_idx == SW'(k)) begin
                    if (i_upd.clr_fresh) begin
                        r_fresh[k] <= 1'b0;
                    end
                    if (i_upd.clr_wait) begin
                        r_wait[k] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STATIONS; k++) begin
            if (w_hit[k]) begin
                r_op[k]  <= i_wr.op;
                r_a[k]   <= i_wr.a;
                r_b[k]   <= i_wr.b;
                r_tag[k] <= w_tag_mod;
            end
        end
    end

    assign o_flags.busy    = r_busy[i_idx];
    assign o_flags.ready   = r_ready[i_idx];
    assign o_flags.fresh   = r_fresh[i_idx];
    assign o_flags.waiting = r_wait[i_idx];
    assign o_op            = r_op[i_idx];
    assign o_a             = r_a[i_idx];
    assign o_b             = r_b[i_idx];
    assign o_tag           = r_tag[i_idx];

endmodule

@@ hw/rtl/round_robin_station_issue_alu_core.sv @@
// Top level: round-robin issue sequencer over the station table and shared ALU.
//
// A write item (cmd 0) loads one station entry. A cycle item (cmd 1) is
// accepted, then the sequencer visits one station per cycle starting after
// the last picked one and scans 1 to NUM_STATIONS stations until it picks
// one; a picked station then passes through the shared ALU (S_EXEC), and
// S_DONE moves the result into the output register. A full scan with no
// pick, or a set stall_req (which skips the scan), sends an empty result to
// S_DONE instead. S_DONE holds while
// the output register is still waiting for its transfer. Each cycle item
// yields exactly one result transfer; write items yield none. The block can
// accept the next item while the previous result sits in the output register.
`timescale 1ns / 1ps

module round_robin_station_issue_alu_core #(
    parameter int NUM_STATIONS = rrs_pkg::NUM_STATIONS_DEF,
    parameter int ROB_ENTRIES  = rrs_pkg::ROB_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_cmd,
    input  logic [rrs_pkg::PORT_IDX_W-1:0]       i_station,
    input  logic [1:0]                           i_op,
    input  logic signed [rrs_pkg::DATA_W-1:0]    i_src_a,
    input  logic signed [rrs_pkg::DATA_W-1:0]    i_src_b,
    input  logic [rrs_pkg::TAG_W-1:0]            i_dest_tag,
    input  logic                                 i_busy_req,
    input  logic                                 i_operands_ready,
    input  logic                                 i_fresh_operand,
    input  logic                                 i_waiting,
    input  logic                                 i_stall_req,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_result_valid,
    output logic signed [rrs_pkg::DATA_W-1:0]    o_result,
    output logic [rrs_pkg::TAG_W-1:0]            o_result_tag,
    output logic [rrs_pkg::PORT_IDX_W-1:0]       o_picked_station,
    output logic                                 o_bad_op
);

    localparam int            SW       = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_STATIONS - 1);
    localparam int            DW       = rrs_pkg::DATA_W;
    localparam int            TW       = rrs_pkg::TAG_W;
    localparam int            PW       = rrs_pkg::PORT_IDX_W;

    rrs_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_ptr, n_ptr;
    logic [SW-1:0]   r_cnt, n_cnt;
    logic [SW-1:0]   r_last, n_last;

    // Result staged by the sequencer before it moves to the output register.
    logic            r_rv, n_rv;
    logic [DW-1:0]   r_res, n_res;
    logic [TW-1:0]   r_rtag, n_rtag;
    logic [PW-1:0]   r_rpick, n_rpick;
    logic            r_rbad, n_rbad;

    logic            r_ovalid, n_ovalid;
    logic            r_o_rv, n_o_rv;
    logic [DW-1:0]   r_o_res, n_o_res;
    logic [TW-1:0]   r_o_tag, n_o_tag;
    logic [PW-1:0]   r_o_pick, n_o_pick;
    logic            r_o_bad, n_o_bad;

    logic                 w_in_acc;
    logic [SW-1:0]        w_start;
    logic [SW-1:0]        w_ptr_inc;
    rrs_pkg::t_st_write   w_wr;
    rrs_pkg::t_st_update  w_upd;
    rrs_pkg::t_st_flags   w_flags;
    rrs_pkg::t_op         w_op;
    logic [DW-1:0]        w_a;
    logic [DW-1:0]        w_b;
    logic [TW-1:0]        w_tag;
    logic [DW-1:0]        w_alu_res;
    logic                 w_alu_bad;

    assign o_stall  = (r_state != rrs_pkg::S_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    assign w_start   = (r_last == LAST_IDX) ? '0 : r_last + 1'b1;
    assign w_ptr_inc = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;

    assign w_wr.en      = w_in_acc && (i_cmd == rrs_pkg::CMD_WRITE);
    assign w_wr.station = i_station;
    assign w_wr.op      = rrs_pkg::t_op'(i_op);
    assign w_wr.a       = i_src_a;
    assign w_wr.b       = i_src_b;
    assign w_wr.tag     = i_dest_tag;
    assign w_wr.busy    = i_busy_req;
    assign w_wr.ready   = i_operands_ready;
    assign w_wr.fresh   = i_fresh_operand;
    assign w_wr.waiting = i_waiting;

    rrs_table #(
        .NUM_STATIONS (NUM_STATIONS),
        .ROB_ENTRIES  (ROB_ENTRIES),
        .SW           (SW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_idx   (r_ptr),
        .i_upd   (w_upd),
        .o_flags (w_flags),
        .o_op    (w_op),
        .o_a     (w_a),
        .o_b     (w_b),
        .o_tag   (w_tag)
    );

    rrs_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_alu_res),
        .o_bad (w_alu_bad)
    );

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_rv     = r_rv;
        n_res    = r_res;
        n_rtag   = r_rtag;
        n_rpick  = r_rpick;
        n_rbad   = r_rbad;
        n_ovalid = r_ovalid;
        n_o_rv   = r_o_rv;
        n_o_res  = r_o_res;
        n_o_tag  = r_o_tag;
        n_o_pick = r_o_pick;
        n_o_bad  = r_o_bad;
        w_upd    = '0;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            rrs_pkg::S_IDLE: begin
                if (w_in_acc && (i_cmd == rrs_pkg::CMD_CYCLE)) begin
                    if (i_stall_req) begin
                        n_rv    = 1'b0;
                        n_res   = '0;
                        n_rtag  = '0;
                        n_rpick = '0;
                        n_rbad  = 1'b0;
                        n_state = rrs_pkg::S_DONE;
                    end else begin
                        n_ptr   = w_start;
                        n_cnt   = '0;
                        n_state = rrs_pkg::S_SCAN;
                    end
                end
            end
            rrs_pkg::S_SCAN: begin
                if (w_flags.busy && w_flags.ready && w_flags.waiting && !w_flags.fresh) begin
                    // Pick: the pointer stays on this station for the ALU cycle.
                    w_upd.clr_wait = 1'b1;
                    n_last         = r_ptr;
                    n_state        = rrs_pkg::S_EXEC;
                end else begin
                    w_upd.clr_fresh = w_flags.busy && w_flags.fresh;
                    if (r_cnt == LAST_IDX) begin
                        n_rv    = 1'b0;
                        n_res   = '0;
                        n_rtag  = '0;
                        n_rpick = '0;
                        n_rbad  = 1'b0;
                        n_state = rrs_pkg::S_DONE;
                    end else begin
                        n_ptr = w_ptr_inc;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            rrs_pkg::S_EXEC: begin
                n_rv    = !w_alu_bad;
                n_res   = w_alu_res;
                n_rtag  = w_tag;
                n_rpick = PW'(r_ptr);
                n_rbad  = w_alu_bad;
                n_state = rrs_pkg::S_DONE;
            end
            rrs_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_o_rv   = r_rv;
                    n_o_res  = r_res;
                    n_o_tag  = r_rtag;
                    n_o_pick = r_rpick;
                    n_o_bad  = r_rbad;
                    n_state  = rrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrs_pkg::S_IDLE;
            r_last   <= LAST_IDX;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_cnt    <= n_cnt;
        r_rv     <= n_rv;
        r_res    <= n_res;
        r_rtag   <= n_rtag;
        r_rpick  <= n_rpick;
        r_rbad   <= n_rbad;
        r_o_rv   <= n_o_rv;
        r_o_res  <= n_o_res;
        r_o_tag  <= n_o_tag;
        r_o_pick <= n_o_pick;
        r_o_bad  <= n_o_bad;
    end

    assign o_valid          = r_ovalid;
    assign o_result_valid   = r_o_rv;
    assign o_result         = r_o_res;
    assign o_result_tag     = r_o_tag;
    assign o_picked_station = r_o_pick;
    assign o_bad_op         = r_o_bad;

`ifndef NO_ASSERTIONS
    a_cycle_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_cmd == rrs_pkg::CMD_CYCLE)) |=> (r_state != rrs_pkg::S_IDLE))
        else $error("cycle transfer did not start the sequencer");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrs_pkg::S_SCAN) |-> (r_cnt <= LAST_IDX))
        else $error("scan ran past the last station");

    a_exec_on_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrs_pkg::S_EXEC) |-> (r_last == r_ptr))
        else $error("ALU cycle is not on the picked station");

    a_bad_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_bad) |-> (!r_o_rv && (r_o_res == '0)))
        else $error("invalid operation produced a result");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_o_rv && !r_o_bad) |-> (r_o_res == '0))
        else $error("result without a pick is not zero");
`endif

endmodule
